// File: design/jev_pkg.sv
// Package for the 3x3 symmetric Jacobi eigenvalue unit.
// Holds fixed constants, the CORDIC arctangent table and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
package jev_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned AngW     = 64;
  localparam int unsigned AccW     = 96;
  localparam int unsigned StepW    = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CfgMaxSweeps = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b1;

  localparam logic signed [AngW-1:0] PiQ30      = 64'sd3373259426;
  localparam logic signed [AngW-1:0] GainInvQ30 = 64'sd652032874;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_VPREP,
    ST_VNORM,
    ST_VITER,
    ST_ROTPREP,
    ST_RITER,
    ST_MUL_CC,
    ST_MUL_SS,
    ST_MUL_SC,
    ST_APP0,
    ST_APP1,
    ST_APP2,
    ST_AQQ0,
    ST_AQQ1,
    ST_AQQ2,
    ST_EP0,
    ST_EP1,
    ST_EQ0,
    ST_EQ1,
    ST_WRITE,
    ST_SORT,
    ST_DONE
  } jev_state_e;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] r;
    r = '0;
    unique case (idx)
      6'd0: r = 64'sd843314857;
      6'd1: r = 64'sd497837829;
      6'd2: r = 64'sd263043837;
      6'd3: r = 64'sd133525159;
      6'd4: r = 64'sd67021687;
      6'd5: r = 64'sd33543516;
      6'd6: r = 64'sd16775851;
      6'd7: r = 64'sd8388437;
      6'd8: r = 64'sd4194283;
      6'd9: r = 64'sd2097149;
      default: begin
        if (idx <= 6'd30) begin
          r = 64'sd1 <<< (6'd30 - idx);
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/jev_cordic.sv
// Shared CORDIC stage for the Jacobi eigenvalue unit: one micro-rotation per cycle.
// Serves both vectoring (atan2) and rotation (sin/cos). Depends on jev_pkg.
`timescale 1ns / 1ps
module jev_cordic (
  input  logic                              vec_mode_i,
  input  logic [jev_pkg::StepW-1:0]         step_i,
  input  logic signed [jev_pkg::AngW-1:0]   x_i,
  input  logic signed [jev_pkg::AngW-1:0]   y_i,
  input  logic signed [jev_pkg::AngW-1:0]   z_i,
  output logic signed [jev_pkg::AngW-1:0]   x_o,
  output logic signed [jev_pkg::AngW-1:0]   y_o,
  output logic signed [jev_pkg::AngW-1:0]   z_o
);
  import jev_pkg::*;

  logic                   dir_pos;
  logic signed [AngW-1:0] xs, ys, at;

  always_comb begin
    xs = x_i >>> step_i;
    ys = y_i >>> step_i;
    at = atan_q30(step_i);
    // vectoring drives y to zero, rotation drives the residual angle to zero
    dir_pos = vec_mode_i ? !y_i[AngW-1] : !z_i[AngW-1];
    if (vec_mode_i ? dir_pos : !dir_pos) begin
      x_o = x_i + ys;
      y_o = y_i - xs;
    end else begin
      x_o = x_i - ys;
      y_o = y_i + xs;
    end
    if (vec_mode_i) begin
      z_o = dir_pos ? z_i + at : z_i - at;
    end else begin
      z_o = dir_pos ? z_i - at : z_i + at;
    end
  end

endmodule

// File: design/jev_mac.sv
// Shared multiply-accumulate for the Jacobi eigenvalue unit: one signed 36x36 product
// per cycle while en_i is high, added into a registered wide accumulator. Depends on jev_pkg.
`timescale 1ns / 1ps
module jev_mac (
  input  logic                             clk_i,
  input  logic                             clr_i,
  input  logic                             en_i,
  input  logic signed [35:0]               a_i,
  input  logic signed [35:0]               b_i,
  output logic signed [jev_pkg::AccW-1:0]  acc_o
);
  import jev_pkg::*;

  logic signed [AccW-1:0] acc_q, acc_d, base;
  logic signed [71:0]     prod;

  // clear and enable together start a new sum with this product
  always_comb begin
    prod = a_i * b_i;
    base = clr_i ? '0 : acc_q;
    acc_d = en_i ? base + AccW'(prod) : base;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// File: design/symmetric_3x3_jacobi_eigenvalues_unit.sv
// One beat at a time: the shared CORDIC stage and shared multiplier set the rate; the
// next beat is taken once the result has been taken. Async active-low reset clears the
// sequencer and loads max_sweeps = 24, off_diag_threshold = 1. Depends on jev_pkg.
`timescale 1ns / 1ps
module symmetric_3x3_jacobi_eigenvalues_unit #(
  parameter int unsigned CORDIC_STEPS = 24,
  parameter int unsigned SWEEP_LIMIT  = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [jev_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [jev_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [jev_pkg::WordW-1:0]   entry_00_i,
  input  logic signed [jev_pkg::WordW-1:0]   entry_01_i,
  input  logic signed [jev_pkg::WordW-1:0]   entry_02_i,
  input  logic signed [jev_pkg::WordW-1:0]   entry_11_i,
  input  logic signed [jev_pkg::WordW-1:0]   entry_12_i,
  input  logic signed [jev_pkg::WordW-1:0]   entry_22_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [jev_pkg::WordW-1:0]   eig_small_o,
  output logic signed [jev_pkg::WordW-1:0]   eig_middle_o,
  output logic signed [jev_pkg::WordW-1:0]   eig_large_o
);
  import jev_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);
  localparam logic [5:0]       SweepCap = 6'(SWEEP_LIMIT);
  localparam logic signed [AngW-1:0] NormMag = 64'sd1 <<< 40;
  localparam logic signed [WordW-1:0] WMax = 32'sh7fffffff;
  localparam logic signed [WordW-1:0] WMin = 32'sh80000000;

  jev_state_e state_q, state_d;

  logic [5:0]            max_sweeps_q;
  logic [CfgDataW-1:0]   thr_q;
  logic signed [WordW-1:0] a00_q, a01_q, a02_q, a11_q, a12_q, a22_q;
  logic [5:0]            rot_q;
  logic [StepW-1:0]      step_q;
  logic [1:0]            piv_q;          // 0:(0,1) 1:(0,2) 2:(1,2)
  logic signed [AngW-1:0] cx_q, cy_q, cz_q;
  logic signed [AngW-1:0] co_q, si_q, cc_q, ss_q, sc_q;
  logic signed [WordW-1:0] npp_q, nqq_q, nep_q;
  logic signed [WordW-1:0] res0_q, res1_q, res2_q;

  // pivot selection
  logic [WordW:0] m01, m02, m12, best;
  logic [1:0]     piv_sel;
  always_comb begin
    m01 = a01_q[WordW-1] ? (WordW+1)'(-$signed({a01_q[WordW-1], a01_q})) : {1'b0, a01_q};
    m02 = a02_q[WordW-1] ? (WordW+1)'(-$signed({a02_q[WordW-1], a02_q})) : {1'b0, a02_q};
    m12 = a12_q[WordW-1] ? (WordW+1)'(-$signed({a12_q[WordW-1], a12_q})) : {1'b0, a12_q};
    best = m01;
    piv_sel = 2'd0;
    if (m02 > best) begin
      best = m02;
      piv_sel = 2'd1;
    end
    if (m12 > best) begin
      best = m12;
      piv_sel = 2'd2;
    end
  end

  // pivot operands by pivot code
  logic signed [WordW-1:0] dpp, dqq, dpq, ep, eq;
  always_comb begin
    unique case (piv_q)
      2'd0: begin dpp = a00_q; dqq = a11_q; dpq = a01_q; ep = a02_q; eq = a12_q; end
      2'd1: begin dpp = a00_q; dqq = a22_q; dpq = a02_q; ep = a01_q; eq = a12_q; end
      default: begin dpp = a11_q; dqq = a22_q; dpq = a12_q; ep = a01_q; eq = a02_q; end
    endcase
  end

  // shared CORDIC stage
  logic signed [AngW-1:0] nx, ny, nz;
  jev_cordic u_cordic (
    .vec_mode_i (state_q == ST_VITER),
    .step_i     (step_q),
    .x_i        (cx_q),
    .y_i        (cy_q),
    .z_i        (cz_q),
    .x_o        (nx),
    .y_o        (ny),
    .z_o        (nz)
  );

  // shared multiplier operand select; clear starts a new sum
  logic signed [35:0] ma, mb;
  logic               mac_clr, mac_en;
  logic signed [AccW-1:0] acc;
  always_comb begin
    ma = '0;
    mb = '0;
    mac_en = 1'b1;
    mac_clr = 1'b0;
    unique case (state_q)
      ST_MUL_CC: begin ma = 36'(co_q); mb = 36'(co_q); end
      ST_MUL_SS: begin ma = 36'(si_q); mb = 36'(si_q); mac_clr = 1'b1; end
      ST_MUL_SC: begin ma = 36'(si_q); mb = 36'(co_q); mac_clr = 1'b1; end
      ST_APP0:   begin ma = 36'(cc_q); mb = 36'(dpp); mac_clr = 1'b1; end
      ST_APP1:   begin ma = -36'(sc_q <<< 1); mb = 36'(dpq); end
      ST_APP2:   begin ma = 36'(ss_q); mb = 36'(dqq); end
      ST_AQQ0:   begin ma = 36'(ss_q); mb = 36'(dpp); mac_clr = 1'b1; end
      ST_AQQ1:   begin ma = 36'(sc_q <<< 1); mb = 36'(dpq); end
      ST_AQQ2:   begin ma = 36'(cc_q); mb = 36'(dqq); end
      ST_EP0:    begin ma = 36'(co_q); mb = 36'(ep); mac_clr = 1'b1; end
      ST_EP1:    begin ma = -36'(si_q); mb = 36'(eq); end
      ST_EQ0:    begin ma = 36'(si_q); mb = 36'(ep); mac_clr = 1'b1; end
      ST_EQ1:    begin ma = 36'(co_q); mb = 36'(eq); end
      default:   begin mac_en = 1'b0; mac_clr = 1'b1; end
    endcase
  end

  jev_mac u_mac (
    .clk_i (clk_i),
    .clr_i (mac_clr),
    .en_i  (mac_en),
    .a_i   (ma),
    .b_i   (mb),
    .acc_o (acc)
  );

  // rescale Q30 and saturate to 32 bits
  logic signed [AccW-1:0] acc_sh;
  logic signed [WordW-1:0] acc_sat;
  always_comb begin
    acc_sh = acc >>> 30;
    if (acc_sh > AccW'(WMax)) begin
      acc_sat = WMax;
    end else if (acc_sh < AccW'(WMin)) begin
      acc_sat = WMin;
    end else begin
      acc_sat = acc_sh[WordW-1:0];
    end
  end

  logic [5:0] limit;
  assign limit = (max_sweeps_q < SweepCap) ? max_sweeps_q : SweepCap;

  logic in_acc, out_acc, norm_done, last_step;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign last_step = (step_q == LastStep);
  always_comb begin
    logic signed [AngW-1:0] ax, ay;
    ax = cx_q[AngW-1] ? -cx_q : cx_q;
    ay = cy_q[AngW-1] ? -cy_q : cy_q;
    norm_done = (ax >= NormMag) || (ay >= NormMag);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_PIVOT;
      ST_PIVOT: begin
        if (rot_q >= limit || best < (WordW+1)'(thr_q)) state_d = ST_SORT;
        else state_d = ST_VPREP;
      end
      ST_VPREP:   state_d = ST_VNORM;
      ST_VNORM: begin
        if (cx_q == '0 && cy_q == '0) state_d = ST_ROTPREP;
        else if (norm_done) state_d = ST_VITER;
      end
      ST_VITER:   if (last_step) state_d = ST_ROTPREP;
      ST_ROTPREP: state_d = ST_RITER;
      ST_RITER:   if (last_step) state_d = ST_MUL_CC;
      ST_MUL_CC:  state_d = ST_MUL_SS;
      ST_MUL_SS:  state_d = ST_MUL_SC;
      ST_MUL_SC:  state_d = ST_APP0;
      ST_APP0:    state_d = ST_APP1;
      ST_APP1:    state_d = ST_APP2;
      ST_APP2:    state_d = ST_AQQ0;
      ST_AQQ0:    state_d = ST_AQQ1;
      ST_AQQ1:    state_d = ST_AQQ2;
      ST_AQQ2:    state_d = ST_EP0;
      ST_EP0:     state_d = ST_EP1;
      ST_EP1:     state_d = ST_EQ0;
      ST_EQ0:     state_d = ST_EQ1;
      ST_EQ1:     state_d = ST_WRITE;
      ST_WRITE:   state_d = ST_PIVOT;
      ST_SORT:    state_d = ST_DONE;
      ST_DONE:    if (out_acc) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      max_sweeps_q <= 6'd24;
      thr_q        <= CfgDataW'(1);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMaxSweeps: max_sweeps_q <= cfg_data_i[5:0];
          default:      thr_q <= cfg_data_i;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // the MAC accumulator holds the previous pair's product when each state is entered,
    // so capture the finished product one state later
    unique case (state_q)
      ST_IDLE: begin
        a00_q <= entry_00_i; a01_q <= entry_01_i; a02_q <= entry_02_i;
        a11_q <= entry_11_i; a12_q <= entry_12_i; a22_q <= entry_22_i;
        rot_q <= '0;
      end
      ST_PIVOT: piv_q <= piv_sel;
      ST_VPREP: begin
        logic signed [AngW-1:0] vy, vx, vz;
        vy = AngW'(dpq) <<< 1;
        vx = AngW'(dqq) - AngW'(dpp);
        vz = '0;
        if (vx < 0) begin
          vz = (vy >= 0) ? PiQ30 : -PiQ30;
          vx = -vx;
          vy = -vy;
        end
        cz_q <= vz;
        cx_q <= vx;
        cy_q <= vy;
        step_q <= '0;
      end
      ST_VNORM: begin
        if (!norm_done && !(cx_q == '0 && cy_q == '0)) begin
          cx_q <= cx_q <<< 1;
          cy_q <= cy_q <<< 1;
        end
        if (cx_q == '0 && cy_q == '0) cz_q <= '0;
      end
      ST_VITER: begin
        cx_q <= nx; cy_q <= ny; cz_q <= nz;
        step_q <= step_q + 1'b1;
      end
      ST_ROTPREP: begin
        cz_q <= cz_q >>> 1;
        cx_q <= GainInvQ30;
        cy_q <= '0;
        step_q <= '0;
      end
      ST_RITER: begin
        cx_q <= nx; cy_q <= ny; cz_q <= nz;
        step_q <= step_q + 1'b1;
        if (last_step) begin
          co_q <= nx;
          si_q <= ny;
        end
      end
      ST_MUL_SS: cc_q <= acc_sh[AngW-1:0];
      ST_MUL_SC: ss_q <= acc_sh[AngW-1:0];
      ST_APP0:   sc_q <= acc_sh[AngW-1:0];
      ST_AQQ0:   npp_q <= acc_sat;
      ST_EP0:    nqq_q <= acc_sat;
      ST_EQ0:    nep_q <= acc_sat;
      ST_WRITE: begin
        rot_q <= rot_q + 1'b1;
        unique case (piv_q)
          2'd0: begin a00_q <= npp_q; a11_q <= nqq_q; a01_q <= '0;
                      a02_q <= nep_q; a12_q <= acc_sat; end
          2'd1: begin a00_q <= npp_q; a22_q <= nqq_q; a02_q <= '0;
                      a01_q <= nep_q; a12_q <= acc_sat; end
          default: begin a11_q <= npp_q; a22_q <= nqq_q; a12_q <= '0;
                      a01_q <= nep_q; a02_q <= acc_sat; end
        endcase
      end
      ST_SORT: begin
        logic signed [WordW-1:0] d0, d1, d2, t;
        d0 = a00_q; d1 = a11_q; d2 = a22_q;
        if (d0 > d1) begin t = d0; d0 = d1; d1 = t; end
        if (d1 > d2) begin t = d1; d1 = d2; d2 = t; end
        if (d0 > d1) begin t = d0; d0 = d1; d1 = t; end
        res0_q <= d0; res1_q <= d1; res2_q <= d2;
      end
      default: ;
    endcase
  end

  assign eig_small_o  = res0_q;
  assign eig_middle_o = res1_q;
  assign eig_large_o  = res2_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(eig_small_o))
    else $error("result dropped under stall");
  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VPREP |-> rot_q < limit) else $error("rotation beyond limit");
`endif

endmodule
